>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ets_cal_pkg.sv
// ----------------------------------------------------------------------------
// ets_cal_pkg
// types and constants shared by the epoch seconds to calendar converter
// ----------------------------------------------------------------------------
package ets_cal_pkg;

   // divider operation selected at load time
   typedef enum logic [1:0] {
      DIV_DAYS = 2'd0,
      DIV_WEEK = 2'd1,
      DIV_HOUR = 2'd2,
      DIV_MIN  = 2'd3
   } div_op_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       div_load;
      div_op_type div_op;
      logic       div_step;
      logic       cap_days;
      logic       cap_wday;
      logic       cap_hour;
      logic       cap_min;
      logic       walk_start;
      logic       out_load;
   } ets_cal_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic div_last;
      logic walk_busy;
   } ets_cal_sts_type;

   // reciprocal divider: quotient in the first step, remainder in the second
   // quotient = ((operand >> prescale) * recip) >> shift, exact over each range
   localparam logic [1:0]  DIV_STEPS    = 2'd2;
   localparam logic [25:0] DAYS_RECIP   = 26'd50903317;
   localparam logic [25:0] WEEK_RECIP   = 26'd74899;
   localparam logic [25:0] HOUR_RECIP   = 26'd9321;
   localparam logic [25:0] MIN_RECIP    = 26'd1093;
   localparam int unsigned DAYS_SHIFT   = 35;
   localparam int unsigned WEEK_SHIFT   = 19;
   localparam int unsigned HOUR_SHIFT   = 21;
   localparam int unsigned MIN_SHIFT    = 14;
   localparam logic [31:0] DAYS_DIVISOR = 32'd86400;
   localparam logic [31:0] WEEK_DIVISOR = 32'd7;
   localparam logic [31:0] HOUR_DIVISOR = 32'd3600;
   localparam logic [31:0] MIN_DIVISOR  = 32'd60;

   // epoch anchors
   localparam logic [31:0] EPOCH_WEEKDAY = 32'd4;
   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
   localparam logic [6:0]  EPOCH_MOD100  = 7'd70;
   localparam logic [8:0]  EPOCH_MOD400  = 9'd370;
   localparam logic [8:0]  YEAR_DAYS     = 9'd365;
   localparam logic [8:0]  LEAP_DAYS     = 9'd366;
   localparam logic [3:0]  MONTH_FEB     = 4'd1;
   localparam logic [3:0]  MONTH_DEC     = 4'd11;

   // days in a month of a common year, month index 0 is january
   function automatic logic [4:0] month_days(input logic [3:0] mon);
      logic [4:0] len;
      case (mon)
         4'd1:                 len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:              len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

>>> src/epoch_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// converts seconds since 1970-01-01 00:00:00 utc to calendar date and time
// ----------------------------------------------------------------------------
// usage:
//   req channel carries one 32-bit seconds count per word (valid/ready).
//   rsp channel returns year, month, day of month, hour, minute, second and
//   weekday (0 is sunday) for each request word, in order.
//   the long part of a conversion is the year walk, one year per cycle from
//   1970 (up to 136 years) plus one month per cycle, running beside a shared
//   reciprocal divider (a quotient step then a remainder step for the day
//   split, weekday, hour and minute).
//   one word is converted at a time; req_ready is high only between words.
//   the result sits in an output register, so the next request is taken
//   while rsp is stalled; a finished conversion then waits until the output
//   register drains before it is written.
//   synchronous reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar
   import ets_cal_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day_of_month,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic [2:0]  rsp_weekday
);

   ets_cal_cmd_type cmd;
   ets_cal_sts_type sts;

   // sequencer
   ets_cal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and result register
   ets_cal_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_epoch_seconds (req_epoch_seconds),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

endmodule

>>> src/ets_cal_ctrl.sv
// ----------------------------------------------------------------------------
// ets_cal_ctrl
// sequencer for the converter: drives the divider phases, starts the
// calendar walk and owns the handshakes of both channels
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ets_cal_ctrl
   import ets_cal_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ets_cal_sts_type sts,
   output ets_cal_cmd_type cmd
);

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_SPLIT   = 11'b000_0000_0010,
      S_WEEK_LD = 11'b000_0000_0100,
      S_WEEK    = 11'b000_0000_1000,
      S_HOUR_LD = 11'b000_0001_0000,
      S_HOUR    = 11'b000_0010_0000,
      S_MIN_LD  = 11'b000_0100_0000,
      S_MIN     = 11'b000_1000_0000,
      S_WAIT    = 11'b001_0000_0000,
      S_DONE    = 11'b010_0000_0000,
      S_SPARE   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.div_load = 1'b1;
               cmd.div_op   = DIV_DAYS;
               state_in     = S_SPLIT;
            end
         end
         S_SPLIT: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_WEEK_LD;
         end
         S_WEEK_LD: begin
            cmd.cap_days   = 1'b1;
            cmd.walk_start = 1'b1;
            cmd.div_load   = 1'b1;
            cmd.div_op     = DIV_WEEK;
            state_in       = S_WEEK;
         end
         S_WEEK: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_HOUR_LD;
         end
         S_HOUR_LD: begin
            cmd.cap_wday = 1'b1;
            cmd.div_load = 1'b1;
            cmd.div_op   = DIV_HOUR;
            state_in     = S_HOUR;
         end
         S_HOUR: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_MIN_LD;
         end
         S_MIN_LD: begin
            cmd.cap_hour = 1'b1;
            cmd.div_load = 1'b1;
            cmd.div_op   = DIV_MIN;
            state_in     = S_MIN;
         end
         S_MIN: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_WAIT;
         end
         S_WAIT: begin
            cmd.cap_min = 1'b1;
            if (!sts.walk_busy) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result word valid flag
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // checks
   `ASSERT_NEXT(a_out_load_valid, clock, reset, cmd.out_load, rsp_valid,
      "result word not presented after output load")
   `ASSERT_IMPLIES(a_walk_start_idle, clock, reset, cmd.walk_start, !sts.walk_busy,
      "calendar walk restarted while still busy")
   `ASSERT_IMPLIES(a_out_load_walk_done, clock, reset, cmd.out_load, !sts.walk_busy,
      "output loaded before calendar walk finished")

endmodule

>>> src/ets_cal_dp.sv
// ----------------------------------------------------------------------------
// ets_cal_dp
// datapath: shared reciprocal divider for days, weekday, hour and minute,
// a year and month walker, and the result word register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ets_cal_dp
   import ets_cal_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [31:0]     req_epoch_seconds,
   input  ets_cal_cmd_type cmd,
   output ets_cal_sts_type sts,
   output logic [11:0]     rsp_year,
   output logic [3:0]      rsp_month,
   output logic [4:0]      rsp_day_of_month,
   output logic [4:0]      rsp_hour,
   output logic [5:0]      rsp_minute,
   output logic [5:0]      rsp_second,
   output logic [2:0]      rsp_weekday
);

   // divider
   logic [31:0] w_ff, w_in;
   logic [15:0] q_ff, q_in;
   div_op_type  op_ff, op_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [24:0] rcp_n;
   logic [25:0] rcp_m;
   logic [50:0] rcp_p;
   logic [15:0] rcp_q;
   logic [31:0] rcp_back;

   // captured partial results
   logic [16:0] tod_ff;
   logic [2:0]  wday_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;

   // calendar walker
   logic        walk_busy_ff, walk_busy_in;
   logic        mphase_ff, mphase_in;
   logic [15:0] rem_ff, rem_in;
   logic [11:0] year_ff, year_in;
   logic [6:0]  c100_ff, c100_in;
   logic [8:0]  c400_ff, c400_in;
   logic [3:0]  mon_ff, mon_in;
   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;

   // result word
   logic [11:0] out_year_ff;
   logic [3:0]  out_month_ff;
   logic [4:0]  out_day_ff;
   logic [4:0]  out_hour_ff;
   logic [5:0]  out_minute_ff;
   logic [5:0]  out_second_ff;
   logic [2:0]  out_wday_ff;

   // prescaled operand and reciprocal, one shared multiplier
   // days drops the 2^7 factor of 86400, hour the 2^4 of 3600, minute the 2^2 of 60
   always_comb begin
      case (op_ff)
         DIV_WEEK: begin
            rcp_n    = 25'(w_ff[15:0]);
            rcp_m    = WEEK_RECIP;
            rcp_back = 32'(q_ff) * WEEK_DIVISOR;
         end
         DIV_HOUR: begin
            rcp_n    = 25'(w_ff[16:4]);
            rcp_m    = HOUR_RECIP;
            rcp_back = 32'(q_ff) * HOUR_DIVISOR;
         end
         DIV_MIN: begin
            rcp_n    = 25'(w_ff[11:2]);
            rcp_m    = MIN_RECIP;
            rcp_back = 32'(q_ff) * MIN_DIVISOR;
         end
         default: begin
            rcp_n    = w_ff[31:7];
            rcp_m    = DAYS_RECIP;
            rcp_back = 32'(q_ff) * DAYS_DIVISOR;
         end
      endcase
      rcp_p = 51'(rcp_n) * 51'(rcp_m);
      case (op_ff)
         DIV_WEEK: rcp_q = 16'(rcp_p >> WEEK_SHIFT);
         DIV_HOUR: rcp_q = 16'(rcp_p >> HOUR_SHIFT);
         DIV_MIN:  rcp_q = 16'(rcp_p >> MIN_SHIFT);
         default:  rcp_q = 16'(rcp_p >> DAYS_SHIFT);
      endcase
   end

   // load operand, then quotient step, then remainder step
   always_comb begin
      w_in   = w_ff;
      q_in   = q_ff;
      op_in  = op_ff;
      cnt_in = cnt_ff;
      if (cmd.div_load) begin
         q_in   = '0;
         op_in  = cmd.div_op;
         cnt_in = DIV_STEPS;
         case (cmd.div_op)
            DIV_WEEK: w_in = 32'(q_ff) + EPOCH_WEEKDAY;
            DIV_HOUR: w_in = 32'(tod_ff);
            DIV_MIN:  w_in = w_ff;
            default:  w_in = req_epoch_seconds;
         endcase
      end else if (cmd.div_step) begin
         if (cnt_ff == DIV_STEPS) begin
            q_in = rcp_q;
         end else begin
            w_in = w_ff - rcp_back;
         end
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff  <= w_in;
      q_ff  <= q_in;
      op_ff <= op_in;
   end

   // capture quotients and remainders as each phase ends
   always_ff @(posedge clock) begin
      if (cmd.cap_days) tod_ff <= w_ff[16:0];
      if (cmd.cap_wday) wday_ff <= w_ff[2:0];
      if (cmd.cap_hour) hour_ff <= q_ff[4:0];
      if (cmd.cap_min) begin
         minute_ff <= q_ff[5:0];
         second_ff <= w_ff[5:0];
      end
   end

   // gregorian leap rule from running residues
   assign leap = (year_ff[1:0] == 2'd0) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));
   assign ylen = leap ? LEAP_DAYS : YEAR_DAYS;
   assign mlen = month_days(mon_ff) + {4'd0, (mon_ff == MONTH_FEB) && leap};

   // remove one year or one month per cycle
   always_comb begin
      walk_busy_in = walk_busy_ff;
      mphase_in    = mphase_ff;
      rem_in       = rem_ff;
      year_in      = year_ff;
      c100_in      = c100_ff;
      c400_in      = c400_ff;
      mon_in       = mon_ff;
      if (cmd.walk_start) begin
         walk_busy_in = 1'b1;
         mphase_in    = 1'b0;
         rem_in       = q_ff;
         year_in      = EPOCH_YEAR;
         c100_in      = EPOCH_MOD100;
         c400_in      = EPOCH_MOD400;
         mon_in       = '0;
      end else if (walk_busy_ff) begin
         if (!mphase_ff) begin
            if (rem_ff < 16'(ylen)) begin
               mphase_in = 1'b1;
            end else begin
               rem_in  = rem_ff - 16'(ylen);
               year_in = year_ff + 12'd1;
               c100_in = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
               c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
            end
         end else begin
            if ((mon_ff == MONTH_DEC) || (rem_ff < 16'(mlen))) begin
               walk_busy_in = 1'b0;
            end else begin
               rem_in = rem_ff - 16'(mlen);
               mon_in = mon_ff + 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_busy_ff <= 1'b0;
         mphase_ff    <= 1'b0;
      end else begin
         walk_busy_ff <= walk_busy_in;
         mphase_ff    <= mphase_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      year_ff <= year_in;
      c100_ff <= c100_in;
      c400_ff <= c400_in;
      mon_ff  <= mon_in;
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_year_ff   <= year_ff;
         out_month_ff  <= mon_ff + 4'd1;
         out_day_ff    <= rem_ff[4:0] + 5'd1;
         out_hour_ff   <= hour_ff;
         out_minute_ff <= minute_ff;
         out_second_ff <= second_ff;
         out_wday_ff   <= wday_ff;
      end
   end

   assign sts.div_last  = (cnt_ff == 2'd1);
   assign sts.walk_busy = walk_busy_ff;

   assign rsp_year         = out_year_ff;
   assign rsp_month        = out_month_ff;
   assign rsp_day_of_month = out_day_ff;
   assign rsp_hour         = out_hour_ff;
   assign rsp_minute       = out_minute_ff;
   assign rsp_second       = out_second_ff;
   assign rsp_weekday      = out_wday_ff;

   // checks
   `ASSERT_IMPLIES(a_step_count, clock, reset, cmd.div_step, cnt_ff != 2'd0,
      "divider stepped past its last step")
   `ASSERT_IMPLIES(a_month_rem, clock, reset, walk_busy_ff && mphase_ff,
      (rem_ff < 16'd366) && (mon_ff <= MONTH_DEC), "month walk out of range")
   `ASSERT_NEXT(a_time_range, clock, reset, cmd.out_load,
      (out_hour_ff < 5'd24) && (out_minute_ff < 6'd60) && (out_second_ff < 6'd60)
      && (out_wday_ff < 3'd7), "time of day or weekday out of range")

endmodule

>>> verif/epoch_seconds_to_calendar_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_tb
// self-checking bench for the seconds to calendar converter
// ----------------------------------------------------------------------------
// a table of hand-picked timestamps runs first (epoch start, unit rollovers,
// leap days, the 2100 non-leap february, 2038 and the top of the 32-bit
// range). random timestamps follow, half of them near new year and february
// boundaries. every rsp word is checked field by field against a behavioral
// calendar predictor, or against hand-typed dates where they are obvious.
// the sender and the receiver idle at different rates across four phases.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_tb;

   // day of week codes
   localparam logic [2:0] SUNDAY    = 3'd0;
   localparam logic [2:0] MONDAY    = 3'd1;
   localparam logic [2:0] TUESDAY   = 3'd2;
   localparam logic [2:0] WEDNESDAY = 3'd3;
   localparam logic [2:0] THURSDAY  = 3'd4;
   localparam logic [2:0] FRIDAY    = 3'd5;
   localparam logic [2:0] SATURDAY  = 3'd6;

   localparam int unsigned DAY_SECS   = 86400;
   localparam int unsigned HOUR_SECS  = 3600;
   localparam int unsigned MIN_SECS   = 60;
   localparam int unsigned FIRST_YEAR = 1970;
   localparam int unsigned LAST_YEAR  = 2106;
   localparam int unsigned FEBRUARY   = 1;
   localparam int unsigned DECEMBER   = 11;
   localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   localparam int PHASES       = 4;
   localparam int PHASE_WORDS  = 100;
   localparam int SETTLE_CYCLES = 250;
   localparam int TABLE_ROWS   = 23;

   // idle percentages per phase: none, sender, receiver, both lightly
   localparam int SEND_IDLE [PHASES] = '{0, 56, 0, 8};
   localparam int RECV_IDLE [PHASES] = '{0, 0, 56, 8};

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  sec;
      logic [2:0]  weekday;
   } calendar_type;

   typedef struct packed {
      logic [31:0]  secs;
      logic         typed;
      calendar_type want;
   } stim_row_type;

   // directed timestamps; typed rows carry a date written out by hand
   stim_row_type stim_table [TABLE_ROWS] = '{
      '{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, THURSDAY}},
      '{32'd1,          1'b0, '0},
      '{32'd59,         1'b0, '0},
      '{32'd60,         1'b0, '0},
      '{32'd3599,       1'b0, '0},
      '{32'd3600,       1'b0, '0},
      '{32'd86399,      1'b1, '{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, THURSDAY}},
      '{32'd86400,      1'b1, '{12'd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0, FRIDAY}},
      '{32'd31535999,   1'b0, '0},
      '{32'd31536000,   1'b1, '{12'd1971, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, FRIDAY}},
      '{32'd68169600,   1'b0, '0},
      '{32'd951782400,  1'b0, '0},
      '{32'd978220800,  1'b0, '0},
      '{32'd4107456000, 1'b0, '0},
      '{32'd4107542400, 1'b0, '0},
      '{32'd4291747199, 1'b0, '0},
      '{32'd4291747200, 1'b0, '0},
      '{32'h7FFF_FFFF,  1'b1, '{12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7, TUESDAY}},
      '{32'h8000_0000,  1'b0, '0},
      '{32'h5555_5555,  1'b0, '0},
      '{32'hAAAA_AAAA,  1'b0, '0},
      '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2, 5'd7, 5'd6, 6'd28, 6'd15, SUNDAY}},
      '{32'hFFFF_FFFE,  1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_epoch_seconds;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [11:0] rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day_of_month;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic [2:0]  rsp_weekday;

   calendar_type pending_dates [$];
   calendar_type want;
   int           mismatches = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;

   epoch_seconds_to_calendar dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_year          (rsp_year),
      .rsp_month         (rsp_month),
      .rsp_day_of_month  (rsp_day_of_month),
      .rsp_hour          (rsp_hour),
      .rsp_minute        (rsp_minute),
      .rsp_second        (rsp_second),
      .rsp_weekday       (rsp_weekday)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // gregorian rule: every fourth year, centuries only when divisible by 400
   function automatic bit is_leap(input int unsigned yr);
      if (yr % 4 != 0) return 1'b0;
      if (yr % 100 != 0) return 1'b1;
      return (yr % 400) == 0;
   endfunction

   // date and time of day for a seconds count, walking years then months
   function automatic calendar_type civil_date_of(input logic [31:0] stamp);
      calendar_type c;
      int unsigned  secs;
      int unsigned  tod;
      int unsigned  days_left;
      int unsigned  yr;
      int unsigned  mon;
      int unsigned  span;
      secs      = stamp;
      tod       = secs % DAY_SECS;
      days_left = secs / DAY_SECS;
      c.weekday = 3'((days_left + THURSDAY) % 7);
      yr        = FIRST_YEAR;
      span      = is_leap(yr) ? 366 : 365;
      while (days_left >= span) begin
         days_left -= span;
         yr++;
         span = is_leap(yr) ? 366 : 365;
      end
      mon = 0;
      while (mon < DECEMBER) begin
         span = MONTH_LEN[mon];
         if (mon == FEBRUARY && is_leap(yr)) span = 29;
         if (days_left < span) break;
         days_left -= span;
         mon++;
      end
      c.year   = 12'(yr);
      c.month  = 4'(mon + 1);
      c.mday   = 5'(days_left + 1);
      c.hour   = 5'(tod / HOUR_SECS);
      c.minute = 6'((tod % HOUR_SECS) / MIN_SECS);
      c.sec    = 6'(tod % MIN_SECS);
      return c;
   endfunction

   // present one word from a falling edge, hold until accepted
   task automatic send_word(input logic [31:0] secs, input logic typed,
                            input calendar_type date);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (!req_ready);
      pending_dates.push_back(typed ? date : civil_date_of(secs));
      @(negedge clock);
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // compare each returned word against the oldest pending date
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            $error("rsp word with no pending date");
            mismatches++;
         end else begin
            want = pending_dates.pop_front();
            if (rsp_year !== want.year) begin
               $error("year: expected %0d, actual %0d", want.year, rsp_year);
               mismatches++;
            end
            if (rsp_month !== want.month) begin
               $error("month: expected %0d, actual %0d", want.month, rsp_month);
               mismatches++;
            end
            if (rsp_day_of_month !== want.mday) begin
               $error("day_of_month: expected %0d, actual %0d", want.mday, rsp_day_of_month);
               mismatches++;
            end
            if (rsp_hour !== want.hour) begin
               $error("hour: expected %0d, actual %0d", want.hour, rsp_hour);
               mismatches++;
            end
            if (rsp_minute !== want.minute) begin
               $error("minute: expected %0d, actual %0d", want.minute, rsp_minute);
               mismatches++;
            end
            if (rsp_second !== want.sec) begin
               $error("second: expected %0d, actual %0d", want.sec, rsp_second);
               mismatches++;
            end
            if (rsp_weekday !== want.weekday) begin
               $error("weekday: expected %0d, actual %0d", want.weekday, rsp_weekday);
               mismatches++;
            end
         end
      end
   end

   // stimulus
   initial begin
      longint    stamp;
      longint    year_start;
      int        yr;
      int        day_off;
      logic [31:0] secs;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_epoch_seconds = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = SEND_IDLE[p];
         recv_idle_pct = RECV_IDLE[p];

         // directed timestamps go out once, with no idling
         if (p == 0) begin
            foreach (stim_table[i]) begin
               send_word(stim_table[i].secs, stim_table[i].typed, stim_table[i].want);
            end
         end

         for (int n = 0; n < PHASE_WORDS; n++) begin
            case ($urandom_range(0, 3))
               0: secs = $urandom;
               3: secs = 32'hFFFF_FFFF - $urandom_range(0, 60 * DAY_SECS);
               default: begin
                  // land within a day of new year, end of january, leap day,
                  // start of march or end of december in a random year
                  yr         = $urandom_range(FIRST_YEAR, LAST_YEAR);
                  year_start = 0;
                  for (int y = FIRST_YEAR; y < yr; y++) begin
                     year_start += is_leap(y) ? 366 : 365;
                  end
                  case ($urandom_range(0, 4))
                     0:       day_off = 0;
                     1:       day_off = 31;
                     2:       day_off = 59;
                     3:       day_off = 60;
                     default: day_off = is_leap(yr) ? 365 : 364;
                  endcase
                  stamp = (year_start + day_off) * DAY_SECS
                          + $urandom_range(0, 2 * DAY_SECS) - DAY_SECS;
                  secs  = 32'(stamp);
               end
            endcase
            send_word(secs, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain, then allow one conversion worth of quiet time
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/ets_cal_pkg.sv
src/ets_cal_ctrl.sv
src/ets_cal_dp.sv
src/epoch_seconds_to_calendar.sv
verif/epoch_seconds_to_calendar_tb.sv
